@@ hw/rtl/asps_pkg.sv @@
package asps_pkg;

  localparam int CELL_W = 6;
  localparam int COORD_W = 3;
  localparam int COST_W = 6;
  localparam int HEUR_W = 4;
  localparam int F_W = 7;
  localparam int CELLS = 64;

  typedef logic [1:0] status_t;
  localparam status_t ST_PATH = 2'd0;
  localparam status_t ST_NOPATH = 2'd1;
  localparam status_t ST_OVERFLOW = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COST_W-1:0]  cost;
    logic [HEUR_W-1:0]  heur;
    logic [CELL_W-1:0]  parent;
  } open_entry_t;

  typedef struct packed {
    logic [CELL_W-1:0] parent;
    logic [COST_W-1:0] steps;
  } node_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_INIT,
    S_SCAN,
    S_SHIFT,
    S_VISIT,
    S_PUSH,
    S_TR_RD,
    S_TR_OUT,
    S_STATUS
  } state_t;

  function automatic logic [HEUR_W-1:0] manhattan(
    input logic [COORD_W-1:0] r1, input logic [COORD_W-1:0] c1,
    input logic [COORD_W-1:0] r2, input logic [COORD_W-1:0] c2);
    logic [COORD_W-1:0] dr;
    logic [COORD_W-1:0] dc;
    dr = (r1 > r2) ? r1 - r2 : r2 - r1;
    dc = (c1 > c2) ? c1 - c2 : c2 - c1;
    return {1'b0, dr} + {1'b0, dc};
  endfunction

  // Row and column offsets on 4 bits; all ones stands for minus one.
  function automatic logic [7:0] step_delta(input logic [1:0] dir);
    logic [7:0] d;
    case (dir)
      2'd0: d = {4'hF, 4'h0};
      2'd1: d = {4'h0, 4'hF};
      2'd2: d = {4'h0, 4'h1};
      2'd3: d = {4'h1, 4'h0};
      default: d = 8'h00;
    endcase
    return d;
  endfunction

endpackage

@@ hw/rtl/asps_open_mem.sv @@
module asps_open_mem
  import asps_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  open_entry_t                wr_data,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output open_entry_t                rd_data
);

  open_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/asps_node_mem.sv @@
module asps_node_mem
  import asps_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [CELL_W-1:0] wr_addr,
  input  node_t             wr_data,
  input  logic [CELL_W-1:0] rd_addr,
  output node_t             rd_data
);

  node_t mem [CELLS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/grid_a_star_path_search.sv @@
// A* search on an 8x8 grid of blocked bits with unit steps and a Manhattan
// heuristic. A load-cell transaction is taken in the idle state. A search
// holds the input off until its last result is loaded into the output
// register. Every pop starts in a setup state. It then scans the open list
// one entry per cycle and closes the gap behind the chosen entry one entry
// per cycle. It then visits the cell and, unless the cell was already
// visited, tries its four neighbors in turn. The open-list memory has a
// single read port, so the scan and the shift each read one entry at a time.
// A search makes at most 257 pops, each over fewer than 256 entries. The path
// then leaves one cell at a time, each read from the node memory before it is
// sent, goal first, with last on the start cell. The visited map is cleared
// as the search is accepted.
module grid_a_star_path_search
  import asps_pkg::*;
#(
  parameter int GRID_ROWS = 8,
  parameter int GRID_COLS = 8,
  parameter int OPEN_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         in_cmd,
  input  logic [2:0]   in_cell_row,
  input  logic [2:0]   in_cell_col,
  input  logic         in_cell_blocked,
  input  logic [2:0]   in_start_row,
  input  logic [2:0]   in_start_col,
  input  logic [2:0]   in_goal_row,
  input  logic [2:0]   in_goal_col,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [1:0]   out_status,
  output logic [2:0]   out_path_row,
  output logic [2:0]   out_path_col,
  output logic [5:0]   out_path_cost,
  output logic         out_last
);

  localparam int IDX_W = $clog2(OPEN_DEPTH);
  localparam int CNT_W = $clog2(OPEN_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(OPEN_DEPTH);
  localparam logic [3:0] ROWS4 = 4'(GRID_ROWS);
  localparam logic [3:0] COLS4 = 4'(GRID_COLS);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [CNT_W-1:0] best_idx_r, best_idx_nxt;
  logic [F_W-1:0]   best_f_r, best_f_nxt;
  open_entry_t      cur_r, cur_nxt;
  logic [1:0]       dir_r, dir_nxt;
  logic [CELLS-1:0] vis_r, vis_nxt;
  logic [CELLS-1:0] blk_r, blk_nxt;
  logic [2:0]       sr_r, sr_nxt, sc_r, sc_nxt, gr_r, gr_nxt, gc_r, gc_nxt;
  logic [CELL_W-1:0] cell_r, cell_nxt;
  logic [5:0]       k_r, k_nxt;
  status_t          stat_r, stat_nxt;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [2:0]       out_row_r, out_col_r;
  logic [5:0]       out_cost_r;
  logic             out_last_r;

  logic             out_load;
  status_t          ld_status;
  logic [2:0]       ld_row, ld_col;
  logic [5:0]       ld_cost;
  logic             ld_last;

  logic             open_we;
  logic [IDX_W-1:0] open_waddr;
  open_entry_t      open_wdata;
  open_entry_t      open_rdata;
  logic             node_we;
  node_t            node_wdata;
  node_t            node_rdata;

  logic             in_acc;
  logic             out_can;
  logic             issue;
  logic [F_W-1:0]   rd_f;
  logic [CELL_W-1:0] cur_ci;
  logic [7:0]       delta;
  logic [3:0]       nr4, nc4;
  logic [CELL_W-1:0] n_ci;
  logic             n_ok;
  logic             tr_last;

  asps_open_mem #(.DEPTH(OPEN_DEPTH)) u_open (
    .clk     (clk),
    .wr_en   (open_we),
    .wr_addr (open_waddr),
    .wr_data (open_wdata),
    .rd_addr (rd_idx_r[IDX_W-1:0]),
    .rd_data (open_rdata)
  );

  asps_node_mem u_node (
    .clk     (clk),
    .wr_en   (node_we),
    .wr_addr (cur_ci),
    .wr_data (node_wdata),
    .rd_addr (cell_r),
    .rd_data (node_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_can = !out_valid_r || !out_stall;
  assign issue = (rd_idx_r < cnt_r);
  assign rd_f = {1'b0, open_rdata.cost} + {3'b000, open_rdata.heur};
  assign cur_ci = {cur_r.row, cur_r.col};
  assign delta = step_delta(dir_r);
  assign nr4 = {1'b0, cur_r.row} + delta[7:4];
  assign nc4 = {1'b0, cur_r.col} + delta[3:0];
  assign n_ci = {nr4[2:0], nc4[2:0]};
  assign n_ok = (nr4 < ROWS4) && (nc4 < COLS4) && !vis_r[n_ci] && !blk_r[n_ci];
  assign tr_last = (cell_r == {sr_r, sc_r}) || (k_r == 6'd63);
  assign node_wdata = '{parent: cur_r.parent, steps: cur_r.cost};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    rd_idx_nxt = rd_idx_r;
    pend_nxt = 1'b0;
    pend_idx_nxt = pend_idx_r;
    best_idx_nxt = best_idx_r;
    best_f_nxt = best_f_r;
    cur_nxt = cur_r;
    dir_nxt = dir_r;
    vis_nxt = vis_r;
    blk_nxt = blk_r;
    sr_nxt = sr_r;
    sc_nxt = sc_r;
    gr_nxt = gr_r;
    gc_nxt = gc_r;
    cell_nxt = cell_r;
    k_nxt = k_r;
    stat_nxt = stat_r;
    open_we = 1'b0;
    open_waddr = '0;
    open_wdata = open_rdata;
    node_we = 1'b0;
    out_load = 1'b0;
    ld_status = ST_PATH;
    ld_row = '0;
    ld_col = '0;
    ld_cost = '0;
    ld_last = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_acc && in_cmd == CMD_LOAD) begin
          if ({1'b0, in_cell_row} < ROWS4 && {1'b0, in_cell_col} < COLS4) begin
            blk_nxt[{in_cell_row, in_cell_col}] = in_cell_blocked;
          end
        end else if (in_acc) begin
          vis_nxt = '0;
          sr_nxt = in_start_row;
          sc_nxt = in_start_col;
          gr_nxt = in_goal_row;
          gc_nxt = in_goal_col;
          if ({1'b0, in_start_row} < ROWS4 && {1'b0, in_start_col} < COLS4) begin
            open_we = 1'b1;
            open_waddr = '0;
            open_wdata = '{row: in_start_row, col: in_start_col, cost: '0,
                           heur: manhattan(in_start_row, in_start_col,
                                           in_goal_row, in_goal_col),
                           parent: {in_start_row, in_start_col}};
            cnt_nxt = CNT_W'(1);
            state_nxt = S_SCAN_INIT;
          end else begin
            cnt_nxt = '0;
            stat_nxt = ST_NOPATH;
            state_nxt = S_STATUS;
          end
        end
      end
      S_SCAN_INIT: begin
        if (cnt_r == '0) begin
          stat_nxt = ST_NOPATH;
          state_nxt = S_STATUS;
        end else begin
          rd_idx_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Each compare works on the read issued the cycle before; ties keep the earlier entry.
        pend_nxt = issue;
        pend_idx_nxt = rd_idx_r;
        rd_idx_nxt = rd_idx_r + CNT_W'(issue);
        if (pend_r && (pend_idx_r == '0 || rd_f < best_f_r)) begin
          best_idx_nxt = pend_idx_r;
          best_f_nxt = rd_f;
          cur_nxt = open_rdata;
        end
        if (!issue && !pend_r) begin
          rd_idx_nxt = best_idx_r + CNT_W'(1);
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        pend_nxt = issue;
        pend_idx_nxt = rd_idx_r;
        rd_idx_nxt = rd_idx_r + CNT_W'(issue);
        if (pend_r) begin
          open_we = 1'b1;
          open_waddr = IDX_W'(pend_idx_r - CNT_W'(1));
          open_wdata = open_rdata;
        end
        if (!issue && !pend_r) begin
          cnt_nxt = cnt_r - CNT_W'(1);
          state_nxt = S_VISIT;
        end
      end
      S_VISIT: begin
        if (vis_r[cur_ci]) begin
          state_nxt = S_SCAN_INIT;
        end else begin
          vis_nxt[cur_ci] = 1'b1;
          node_we = 1'b1;
          if (cur_r.row == gr_r && cur_r.col == gc_r) begin
            cell_nxt = cur_ci;
            k_nxt = '0;
            state_nxt = S_TR_RD;
          end else begin
            dir_nxt = '0;
            state_nxt = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        dir_nxt = dir_r + 2'd1;
        if (dir_r == 2'd3) begin
          state_nxt = S_SCAN_INIT;
        end
        if (n_ok && cnt_r >= DEPTH_C) begin
          stat_nxt = ST_OVERFLOW;
          state_nxt = S_STATUS;
        end else if (n_ok) begin
          open_we = 1'b1;
          open_waddr = cnt_r[IDX_W-1:0];
          open_wdata = '{row: nr4[2:0], col: nc4[2:0], cost: cur_r.cost + 6'd1,
                         heur: manhattan(nr4[2:0], nc4[2:0], gr_r, gc_r),
                         parent: cur_ci};
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_TR_RD: begin
        state_nxt = S_TR_OUT;
      end
      S_TR_OUT: begin
        if (out_can) begin
          out_load = 1'b1;
          ld_status = ST_PATH;
          ld_row = cell_r[5:3];
          ld_col = cell_r[2:0];
          ld_cost = node_rdata.steps;
          ld_last = tr_last;
          if (tr_last) begin
            state_nxt = S_IDLE;
          end else begin
            cell_nxt = node_rdata.parent;
            k_nxt = k_r + 6'd1;
            state_nxt = S_TR_RD;
          end
        end
      end
      S_STATUS: begin
        if (out_can) begin
          out_load = 1'b1;
          ld_status = stat_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      pend_r <= 1'b0;
      vis_r <= '0;
      blk_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      pend_r <= pend_nxt;
      vis_r <= vis_nxt;
      blk_r <= blk_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_f_r <= best_f_nxt;
    cur_r <= cur_nxt;
    dir_r <= dir_nxt;
    sr_r <= sr_nxt;
    sc_r <= sc_nxt;
    gr_r <= gr_nxt;
    gc_r <= gc_nxt;
    cell_r <= cell_nxt;
    k_r <= k_nxt;
    stat_r <= stat_nxt;
    if (out_load) begin
      out_status_r <= ld_status;
      out_row_r <= ld_row;
      out_col_r <= ld_col;
      out_cost_r <= ld_cost;
      out_last_r <= ld_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_path_row = out_row_r;
  assign out_path_col = out_col_r;
  assign out_path_cost = out_cost_r;
  assign out_last = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("open list count beyond its depth");

  a_search_clears_visited: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_SEARCH) |=> (vis_r == '0))
    else $error("visited map not cleared at search start");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while held");

  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && pend_r) |-> (pend_idx_r != '0))
    else $error("shift writes below the list head");

endmodule

@@ bench/asps_checker.sv @@
`timescale 1ns / 1ps

module asps_checker
  import asps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_cmd,
  input  logic [2:0] in_cell_row,
  input  logic [2:0] in_cell_col,
  input  logic       in_cell_blocked,
  input  logic [2:0] in_start_row,
  input  logic [2:0] in_start_col,
  input  logic [2:0] in_goal_row,
  input  logic [2:0] in_goal_col,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_status,
  input  logic [2:0] out_path_row,
  input  logic [2:0] out_path_col,
  input  logic [5:0] out_path_cost,
  input  logic       out_last,
  output int         errors,
  output int         pending,
  output int         results_seen
);

  typedef struct packed {
    status_t    status;
    logic [2:0] row;
    logic [2:0] col;
    logic [5:0] cost;
    logic       last;
  } path_step_t;

  path_step_t  expected_path[$];
  bit          wall[64];
  bit          seen[64];
  logic [5:0]  parent_of[64];
  logic [5:0]  steps_of[64];
  open_entry_t frontier[256];
  int          frontier_n;

  localparam int FRONTIER_MAX = 256;

  assign pending = expected_path.size();

  function automatic int grid_dist(int r1, int c1, int r2, int c2);
    int dr;
    int dc;
    dr = (r1 > r2) ? r1 - r2 : r2 - r1;
    dc = (c1 > c2) ? c1 - c2 : c2 - c1;
    return dr + dc;
  endfunction

  task automatic push_status(status_t st);
    path_step_t p;
    p = '{status: st, row: 3'd0, col: 3'd0, cost: 6'd0, last: 1'b1};
    expected_path.push_back(p);
  endtask

  task automatic predict_search(int sr, int sc, int gr, int gc);
    int dr4[4];
    int dc4[4];
    int best;
    int best_f;
    int f;
    int ci;
    int nr;
    int nc;
    int ni;
    int node_idx;
    int k;
    bit at_start;
    open_entry_t cur;
    path_step_t p;
    dr4 = '{-1, 0, 0, 1};
    dc4 = '{0, -1, 1, 0};
    foreach (seen[i]) seen[i] = 1'b0;
    frontier[0] = '{row: 3'(sr), col: 3'(sc), cost: 6'd0,
                    heur: 4'(grid_dist(sr, sc, gr, gc)), parent: 6'(sr * 8 + sc)};
    frontier_n = 1;
    while (frontier_n > 0) begin
      best = 0;
      best_f = frontier[0].cost + frontier[0].heur;
      for (int i = 1; i < frontier_n; i++) begin
        f = frontier[i].cost + frontier[i].heur;
        if (f < best_f) begin
          best_f = f;
          best = i;
        end
      end
      cur = frontier[best];
      for (int i = best; i + 1 < frontier_n; i++) frontier[i] = frontier[i + 1];
      frontier_n--;
      ci = cur.row * 8 + cur.col;
      if (seen[ci]) continue;
      seen[ci] = 1'b1;
      parent_of[ci] = cur.parent;
      steps_of[ci] = cur.cost;
      if (cur.row == gr && cur.col == gc) begin
        node_idx = ci;
        k = 0;
        while (k < 64) begin
          at_start = (node_idx == sr * 8 + sc) || (k == 63);
          p = '{status: ST_PATH, row: 3'(node_idx >> 3), col: 3'(node_idx & 7),
                cost: steps_of[node_idx], last: at_start};
          expected_path.push_back(p);
          k++;
          if (at_start) break;
          node_idx = parent_of[node_idx];
        end
        return;
      end
      for (int d = 0; d < 4; d++) begin
        nr = cur.row + dr4[d];
        nc = cur.col + dc4[d];
        if (nr < 0 || nr > 7 || nc < 0 || nc > 7) continue;
        ni = nr * 8 + nc;
        if (seen[ni] || wall[ni]) continue;
        if (frontier_n >= FRONTIER_MAX) begin
          push_status(ST_OVERFLOW);
          return;
        end
        frontier[frontier_n] = '{row: 3'(nr), col: 3'(nc), cost: cur.cost + 6'd1,
                                 heur: 4'(grid_dist(nr, nc, gr, gc)), parent: 6'(ci)};
        frontier_n++;
      end
    end
    push_status(ST_NOPATH);
  endtask

  task automatic report(string what, int want, int got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    errors++;
  endtask

  initial begin
    errors = 0;
    results_seen = 0;
    foreach (wall[i]) wall[i] = 1'b0;
  end

  always @(posedge clk) begin
    path_step_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_path.size() == 0) begin
        $display("[%0t] result transaction with nothing expected", $realtime);
        errors++;
      end else begin
        want = expected_path.pop_front();
        if (out_status !== want.status) report("status", want.status, out_status);
        if (out_path_row !== want.row) report("path_row", want.row, out_path_row);
        if (out_path_col !== want.col) report("path_col", want.col, out_path_col);
        if (out_path_cost !== want.cost) report("path_cost", want.cost, out_path_cost);
        if (out_last !== want.last) report("last", want.last, out_last);
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      if (in_cmd == CMD_LOAD) begin
        wall[in_cell_row * 8 + in_cell_col] = in_cell_blocked;
      end else begin
        predict_search(in_start_row, in_start_col, in_goal_row, in_goal_col);
      end
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb
  import asps_pkg::*;
();

  localparam int CYCLE_LIMIT = 20000000;
  localparam int DRAIN_CYCLES = 10000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_cmd;
  logic [2:0] in_cell_row;
  logic [2:0] in_cell_col;
  logic       in_cell_blocked;
  logic [2:0] in_start_row;
  logic [2:0] in_start_col;
  logic [2:0] in_goal_row;
  logic [2:0] in_goal_col;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_status;
  logic [2:0] out_path_row;
  logic [2:0] out_path_col;
  logic [5:0] out_path_cost;
  logic       out_last;

  int  errors;
  int  pending;
  int  results_seen;
  int  cycles;
  int  loads_sent;
  int  searches_sent;
  bit  sender_busy_stretch;
  bit  long_hold_done;

  grid_a_star_path_search dut (.*);

  asps_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random back-pressure, one long hold-off partway through.
  initial begin
    int n;
    out_stall = 1'b1;
    long_hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!long_hold_done && results_seen >= 30) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
      end
      n = (results_seen % 200 < 50) ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send(logic cmd, logic [2:0] cr, logic [2:0] cc, logic cb,
                      logic [2:0] sr, logic [2:0] sc, logic [2:0] gr, logic [2:0] gc);
    int gap;
    gap = sender_busy_stretch ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_cell_row <= cr;
    in_cell_col <= cc;
    in_cell_blocked <= cb;
    in_start_row <= sr;
    in_start_col <= sc;
    in_goal_row <= gr;
    in_goal_col <= gc;
    do @(posedge clk); while (in_stall);
    if (cmd == CMD_LOAD) loads_sent++;
    else searches_sent++;
  endtask

  // The unused half of each transaction carries random bits.
  task automatic load_cell(logic [2:0] r, logic [2:0] c, logic b);
    send(CMD_LOAD, r, c, b, 3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom));
  endtask

  task automatic search(logic [2:0] sr, logic [2:0] sc, logic [2:0] gr, logic [2:0] gc);
    send(CMD_SEARCH, 3'($urandom), 3'($urandom), 1'($urandom), sr, sc, gr, gc);
  endtask

  initial begin
    cycles = 0;
    loads_sent = 0;
    searches_sent = 0;
    sender_busy_stretch = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_LOAD;
    in_cell_row = '0;
    in_cell_col = '0;
    in_cell_blocked = 1'b0;
    in_start_row = '0;
    in_start_col = '0;
    in_goal_row = '0;
    in_goal_col = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners of the search.
    search(3'd0, 3'd0, 3'd0, 3'd0);
    search(3'd0, 3'd0, 3'd7, 3'd7);
    search(3'd7, 3'd7, 3'd0, 3'd0);
    search(3'd7, 3'd0, 3'd0, 3'd7);
    load_cell(3'd3, 3'd3, 1'b1);
    search(3'd3, 3'd3, 3'd3, 3'd6);
    load_cell(3'd5, 3'd5, 1'b1);
    search(3'd0, 3'd0, 3'd5, 3'd5);
    search(3'd5, 3'd5, 3'd5, 3'd5);
    load_cell(3'd0, 3'd6, 1'b1);
    load_cell(3'd1, 3'd7, 1'b1);
    search(3'd7, 3'd0, 3'd0, 3'd7);
    search(3'd0, 3'd7, 3'd7, 3'd0);
    // A wall across column 4 with one gap; cells (0,6) and (1,7) still wall in the goal.
    for (int r = 0; r < 7; r++) load_cell(3'(r), 3'd4, 1'b1);
    search(3'd0, 3'd0, 3'd0, 3'd7);
    for (int r = 0; r < 8; r++) load_cell(3'(r), 3'd4, 1'b0);
    load_cell(3'd0, 3'd6, 1'b0);
    load_cell(3'd1, 3'd7, 1'b0);

    for (int i = 0; i < 70; i++) begin
      sender_busy_stretch = (i >= 40 && i < 60);
      if ($urandom_range(0, 9) < 6)
        load_cell(3'($urandom), 3'($urandom), $urandom_range(0, 9) < 3);
      else
        search(3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom));
    end
    in_valid <= 1'b0;

    while (pending > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d cell writes and %0d searches; checked %0d result transactions.",
             loads_sent, searches_sent, results_seen);
    $display("Back-pressure included a long result hold-off with the input side waiting.");
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/asps_pkg.sv
hw/rtl/asps_open_mem.sv
hw/rtl/asps_node_mem.sv
hw/rtl/grid_a_star_path_search.sv
bench/asps_checker.sv
bench/tb.sv
